/* design/cfba_pkg.sv */
// ---------------------------------------------------------------------------
// cfba_pkg
// Shared types and constants for the cached fixed block allocator: field
// widths, command codes, controller states and the controller/datapath links.
// ---------------------------------------------------------------------------
`default_nettype none

package cfba_pkg;

    // Fixed field widths of the request and result transfers.
    localparam int IDX_W = 10;
    localparam int REQ_W = 3;

    // Request command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_EXHAUSTED = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_POP,
        ST_REFILL,
        ST_SLAB,
        ST_SPILL
    } state_t;

    // Source of the result registers.
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FAIL,
        RES_READ
    } res_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;
        logic     pop;
        logic     push;
        logic     cnt_set_batch;
        logic     cnt_set_spill;
        logic     gcount_dec;
        logic     gcount_inc;
        logic     slabs_inc;
        logic     step_clr;
        logic     step_inc;
        logic     grefill;
        logic     slab_fill;
        logic     spill;
        logic     res_load;
        res_sel_t res_sel;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_valid;
        logic is_free;
        logic cnt_zero;
        logic cnt_full;
        logic gc_zero;
        logic gc_full;
        logic slabs_left;
        logic step_end;
        logic step_last;
    } dp_stat_t;

endpackage

`default_nettype wire

/* design/cached_fixed_block_allocator.sv */
// ---------------------------------------------------------------------------
// cached_fixed_block_allocator
// Fixed-size block allocator with a local free stack per requester, a global
// stack of batches and on-demand slab creation.
// ---------------------------------------------------------------------------
// Usage:
//   A request transfer (cmd, requester, freed_block) is taken at a rising
//   edge where start is high and busy is low. One result (granted_block,
//   status) follows, shown for exactly one cycle with done high; the
//   receiver cannot stall it.
//   An allocate from a non-empty local stack passes the decision and pop
//   states; done rises after the pop state for an allocate and straight after
//   the decision state for a free. A new request may be given while the
//   previous result is being produced.
//   An allocate that finds the local stack empty first copies a global batch
//   or builds a fresh slab; both include a second decision state before the
//   pop.
//   A free that overflows the local stack moves BATCH entries into the
//   global store. These transfers move one entry per cycle through the single
//   write port of the local stack RAM, or of the global batch RAM for a spill.
//   Out-of-range requesters return zero with status ok; an allocate with no
//   block left returns status 1.
//   Reset clears all counts; no clearing pass runs over the RAMs.
// ---------------------------------------------------------------------------
`default_nettype none

module cached_fixed_block_allocator #(
    parameter int NUM_REQUESTERS = 8,
    parameter int BATCH          = 16,
    parameter int MAX_BLOCKS     = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        cmd,
    input  wire logic [cfba_pkg::REQ_W-1:0]  requester,
    input  wire logic [cfba_pkg::IDX_W-1:0]  freed_block,
    output logic                             done,
    output logic      [cfba_pkg::IDX_W-1:0]  granted_block,
    output logic                             status
);

    import cfba_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // Controller.
    cfba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    // Datapath.
    cfba_datapath #(
        .NUM_REQUESTERS (NUM_REQUESTERS),
        .BATCH          (BATCH),
        .MAX_BLOCKS     (MAX_BLOCKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cmd           (cmd),
        .requester     (requester),
        .freed_block   (freed_block),
        .done          (done),
        .granted_block (granted_block),
        .status        (status)
    );

endmodule

`default_nettype wire

/* design/cfba_ram.sv */
// ---------------------------------------------------------------------------
// cfba_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read data output.
// ---------------------------------------------------------------------------
`default_nettype none

module cfba_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/cfba_ctrl.sv */
// ---------------------------------------------------------------------------
// cfba_ctrl
// Controller state machine: decides each request's path and sequences the
// batch refill, slab fill and spill transfers in the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module cfba_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire cfba_pkg::dp_stat_t stat,
    output cfba_pkg::dp_cmd_t       ctl
);

    import cfba_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A request is taken while idle or while the pop result is loaded.
    assign busy   = !((state_reg == ST_IDLE) || (state_reg == ST_POP));
    assign accept = start && !busy;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!stat.req_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (!stat.is_free)
                begin
                    if (!stat.cnt_zero)
                    begin
                        state_next = ST_POP;
                    end
                    else if (!stat.gc_zero)
                    begin
                        state_next = ST_REFILL;
                    end
                    else if (stat.slabs_left)
                    begin
                        state_next = ST_SLAB;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (stat.cnt_full && !stat.gc_full)
                begin
                    state_next = ST_SPILL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                state_next = accept ? ST_DECIDE : ST_IDLE;
            end
            ST_REFILL:
            begin
                if (stat.step_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_SLAB:
            begin
                if (stat.step_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_SPILL:
            begin
                if (stat.step_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        ctl        = '0;
        ctl.accept = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_DECIDE:
            begin
                if (!stat.req_valid)
                begin
                    ctl.res_load = 1'b1;
                    ctl.res_sel  = RES_ZERO;
                end
                else if (!stat.is_free)
                begin
                    if (!stat.cnt_zero)
                    begin
                        ctl.pop = 1'b1;
                    end
                    else if (!stat.gc_zero)
                    begin
                        ctl.gcount_dec = 1'b1;
                        ctl.step_clr   = 1'b1;
                    end
                    else if (stat.slabs_left)
                    begin
                        ctl.step_clr = 1'b1;
                    end
                    else
                    begin
                        ctl.res_load = 1'b1;
                        ctl.res_sel  = RES_FAIL;
                    end
                end
                else if (stat.cnt_full && stat.gc_full)
                begin
                    // Local stack and global store full: the freed index is dropped.
                    ctl.res_load = 1'b1;
                    ctl.res_sel  = RES_ZERO;
                end
                else if (stat.cnt_full)
                begin
                    ctl.push     = 1'b1;
                    ctl.step_clr = 1'b1;
                end
                else
                begin
                    ctl.push     = 1'b1;
                    ctl.res_load = 1'b1;
                    ctl.res_sel  = RES_ZERO;
                end
            end
            ST_POP:
            begin
                ctl.res_load = 1'b1;
                ctl.res_sel  = RES_READ;
            end
            ST_REFILL:
            begin
                ctl.grefill = 1'b1;
                if (stat.step_end)
                begin
                    ctl.cnt_set_batch = 1'b1;
                end
                else
                begin
                    ctl.step_inc = 1'b1;
                end
            end
            ST_SLAB:
            begin
                ctl.slab_fill = 1'b1;
                ctl.step_inc  = 1'b1;
                if (stat.step_last)
                begin
                    ctl.slabs_inc     = 1'b1;
                    ctl.cnt_set_batch = 1'b1;
                end
            end
            ST_SPILL:
            begin
                ctl.spill = 1'b1;
                if (stat.step_end)
                begin
                    ctl.gcount_inc    = 1'b1;
                    ctl.cnt_set_spill = 1'b1;
                    ctl.res_load      = 1'b1;
                    ctl.res_sel       = RES_ZERO;
                end
                else
                begin
                    ctl.step_inc = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // The pop result is always preceded by the decision cycle that read it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> ($past(state_reg) == ST_DECIDE))
        else $error("pop result without a preceding decision");

    // An accepted request is decided in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DECIDE))
        else $error("accepted request not decided");

    // A spill only runs while the global store has room for the batch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPILL) |-> !stat.gc_full)
        else $error("spill into a full global store");

endmodule

`default_nettype wire

/* design/cfba_datapath.sv */
// ---------------------------------------------------------------------------
// cfba_datapath
// Datapath: request registers, local counts, global batch and slab counters,
// the local stack RAM, the global batch RAM and the result registers.
// ---------------------------------------------------------------------------
`default_nettype none

module cfba_datapath #(
    parameter int NUM_REQUESTERS = 8,
    parameter int BATCH          = 16,
    parameter int MAX_BLOCKS     = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cfba_pkg::dp_cmd_t           ctl,
    output cfba_pkg::dp_stat_t               stat,
    input  wire logic                        cmd,
    input  wire logic [cfba_pkg::REQ_W-1:0]  requester,
    input  wire logic [cfba_pkg::IDX_W-1:0]  freed_block,
    output logic                             done,
    output logic      [cfba_pkg::IDX_W-1:0]  granted_block,
    output logic                             status
);

    import cfba_pkg::*;

    localparam int LOCAL_CAP = 2 * BATCH + 1;
    localparam int NUM_SLABS = MAX_BLOCKS / BATCH;
    localparam int LDEPTH    = NUM_REQUESTERS * LOCAL_CAP;
    localparam int GDEPTH    = NUM_SLABS * BATCH;
    localparam int LA_W      = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int GA_W      = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int CNT_W     = $clog2(LOCAL_CAP + 1);
    localparam int GC_W      = $clog2(NUM_SLABS + 1);
    localparam int STEP_W    = $clog2(BATCH + 1);
    localparam int RQ_W      = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam int SV_W      = $clog2(MAX_BLOCKS + 1);

    // Request registers.
    logic             cmd_reg;
    logic [REQ_W-1:0] req_reg;
    logic [IDX_W-1:0] fb_reg;
    logic [LA_W-1:0]  base_reg;

    // Control counters.
    logic [CNT_W-1:0]  cnt_reg  [NUM_REQUESTERS];
    logic [CNT_W-1:0]  cnt_next [NUM_REQUESTERS];
    logic [GC_W-1:0]   gcount_reg;
    logic [GC_W-1:0]   gcount_next;
    logic [GC_W-1:0]   slabs_reg;
    logic [GC_W-1:0]   slabs_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    // Result registers.
    logic             done_reg;
    logic             done_next;
    logic [IDX_W-1:0] granted_reg;
    logic [IDX_W-1:0] granted_next;
    logic             status_reg;
    logic             status_next;

    // Derived values.
    logic [RQ_W-1:0]   req_idx;
    logic [CNT_W-1:0]  cur_cnt;
    logic [STEP_W-1:0] step_m1;
    logic [GA_W-1:0]   gbase;
    logic [IDX_W-1:0]  slab_val;

    // RAM ports.
    logic             l_we;
    logic [LA_W-1:0]  l_waddr;
    logic [IDX_W-1:0] l_wdata;
    logic [LA_W-1:0]  l_raddr;
    logic [IDX_W-1:0] l_rdata;
    logic             g_we;
    logic [GA_W-1:0]  g_waddr;
    logic [IDX_W-1:0] g_wdata;
    logic [GA_W-1:0]  g_raddr;
    logic [IDX_W-1:0] g_rdata;

    assign req_idx  = RQ_W'(req_reg);
    assign cur_cnt  = cnt_reg[req_idx];
    assign step_m1  = step_reg - STEP_W'(1);
    assign gbase    = GA_W'(int'(gcount_reg) * BATCH);
    assign slab_val = IDX_W'(SV_W'(int'(slabs_reg) * BATCH) + SV_W'(step_reg));

    // Status toward the controller.
    always_comb
    begin
        stat.req_valid  = int'(req_reg) < NUM_REQUESTERS;
        stat.is_free    = (cmd_reg == CMD_FREE);
        stat.cnt_zero   = (cur_cnt == '0);
        stat.cnt_full   = (cur_cnt == CNT_W'(2 * BATCH));
        stat.gc_zero    = (gcount_reg == '0);
        stat.gc_full    = (gcount_reg == GC_W'(NUM_SLABS));
        stat.slabs_left = (slabs_reg != GC_W'(NUM_SLABS));
        stat.step_end   = (step_reg == STEP_W'(BATCH));
        stat.step_last  = (step_reg == STEP_W'(BATCH - 1));
    end

    // Request capture on an accepted transfer.
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= cmd;
            req_reg  <= requester;
            fb_reg   <= freed_block;
            base_reg <= LA_W'(int'(requester) * LOCAL_CAP);
        end
    end

    // RAM address and data selection.
    always_comb
    begin
        l_we    = 1'b0;
        l_waddr = base_reg + LA_W'(cur_cnt);
        l_wdata = fb_reg;
        l_raddr = base_reg + LA_W'(cur_cnt - CNT_W'(1));
        g_we    = 1'b0;
        g_waddr = gbase + GA_W'(step_m1);
        g_wdata = l_rdata;
        g_raddr = gbase + GA_W'(step_reg);
        if (ctl.push)
        begin
            l_we = 1'b1;
        end
        // Batch refill: the registered read of global entry i lands at base + i.
        if (ctl.grefill && (step_reg != '0))
        begin
            l_we    = 1'b1;
            l_waddr = base_reg + LA_W'(step_m1);
            l_wdata = g_rdata;
        end
        // Slab fill: ascending indices of the fresh slab.
        if (ctl.slab_fill)
        begin
            l_we    = 1'b1;
            l_waddr = base_reg + LA_W'(step_reg);
            l_wdata = slab_val;
        end
        // Spill: read the local top downward, write each registered entry to the batch.
        if (ctl.spill)
        begin
            l_raddr = base_reg + LA_W'(2 * BATCH) - LA_W'(step_reg);
            g_we    = (step_reg != '0);
        end
    end

    // Counter updates.
    always_comb
    begin
        cnt_next    = cnt_reg;
        gcount_next = gcount_reg;
        slabs_next  = slabs_reg;
        step_next   = step_reg;
        if (ctl.pop)
        begin
            cnt_next[req_idx] = cur_cnt - CNT_W'(1);
        end
        else if (ctl.push)
        begin
            cnt_next[req_idx] = cur_cnt + CNT_W'(1);
        end
        else if (ctl.cnt_set_batch)
        begin
            cnt_next[req_idx] = CNT_W'(BATCH);
        end
        else if (ctl.cnt_set_spill)
        begin
            cnt_next[req_idx] = CNT_W'(BATCH + 1);
        end
        if (ctl.gcount_dec)
        begin
            gcount_next = gcount_reg - GC_W'(1);
        end
        else if (ctl.gcount_inc)
        begin
            gcount_next = gcount_reg + GC_W'(1);
        end
        if (ctl.slabs_inc)
        begin
            slabs_next = slabs_reg + GC_W'(1);
        end
        if (ctl.step_clr)
        begin
            step_next = '0;
        end
        else if (ctl.step_inc)
        begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    // Result selection.
    always_comb
    begin
        done_next    = ctl.res_load;
        granted_next = granted_reg;
        status_next  = status_reg;
        if (ctl.res_load)
        begin
            unique case (ctl.res_sel)
                RES_ZERO:
                begin
                    granted_next = '0;
                    status_next  = STATUS_OK;
                end
                RES_FAIL:
                begin
                    granted_next = '0;
                    status_next  = STATUS_EXHAUSTED;
                end
                RES_READ:
                begin
                    granted_next = l_rdata;
                    status_next  = STATUS_OK;
                end
                default:
                begin
                    granted_next = '0;
                    status_next  = STATUS_OK;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REQUESTERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            gcount_reg <= '0;
            slabs_reg  <= '0;
            step_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            gcount_reg <= gcount_next;
            slabs_reg  <= slabs_next;
            step_reg   <= step_next;
            done_reg   <= done_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    assign done          = done_reg;
    assign granted_block = granted_reg;
    assign status        = status_reg;

    // Local stacks, one region of LOCAL_CAP entries per requester.
    cfba_ram #(
        .WIDTH (IDX_W),
        .DEPTH (LDEPTH)
    ) u_local_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // Global stack of batches, BATCH entries per slot.
    cfba_ram #(
        .WIDTH (IDX_W),
        .DEPTH (GDEPTH)
    ) u_global_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    // A pop is only issued on a non-empty local stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> (cur_cnt != '0))
        else $error("pop from an empty local stack");

    // The global batch count stays within the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        gcount_reg <= GC_W'(NUM_SLABS))
        else $error("global batch count overflow");

    // A failed allocate grants no block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg) |-> (granted_reg == '0))
        else $error("failed allocate with a nonzero grant");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for the cached fixed block allocator. A driver
// feeds request transfers from a queue with random idle bursts, and a monitor
// predicts each grant from its own copy of the local stacks, the global batch
// store and the slab count, then compares every result strobe against it.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cfba_pkg::*;

    // Configuration of the block under test.
    localparam int NREQ         = 8;
    localparam int BATCH        = 16;
    localparam int MAXB         = 1024;
    localparam int LCAP         = 2 * BATCH + 1;
    localparam int NSLABS       = MAXB / BATCH;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic             op;
        logic [REQ_W-1:0] who;
        logic [IDX_W-1:0] idx;
    } request_t;

    typedef struct packed {
        logic [IDX_W-1:0] block;
        logic             stat;
    } grant_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             start       = 1'b0;
    logic             cmd         = CMD_ALLOC;
    logic [REQ_W-1:0] requester   = '0;
    logic [IDX_W-1:0] freed_block = '0;
    logic             busy;
    logic             done;
    logic [IDX_W-1:0] granted_block;
    logic             status;

    request_t    pending_requests[$];
    grant_t      expected_grants[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned gap_left    = 0;
    bit          gaps_on     = 1'b0;

    // Shadow of the allocator state.
    logic [IDX_W-1:0] shadow_stack [NREQ][LCAP];
    int unsigned      shadow_count [NREQ];
    logic [IDX_W-1:0] shadow_batches [NSLABS*BATCH];
    int unsigned      shadow_batch_count = 0;
    int unsigned      shadow_slabs = 0;

    cached_fixed_block_allocator #(
        .NUM_REQUESTERS(NREQ),
        .BATCH         (BATCH),
        .MAX_BLOCKS    (MAXB)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .requester    (requester),
        .freed_block  (freed_block),
        .done         (done),
        .granted_block(granted_block),
        .status       (status)
    );

    // Clock generation.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one accepted request to the shadow state and returns its grant.
    function automatic grant_t predict_grant(request_t req);
        grant_t      res;
        int unsigned cnt;
        int unsigned g;
        int unsigned first;
        res.block = '0;
        res.stat  = STATUS_OK;
        if (req.who >= NREQ)
            return res;
        cnt = shadow_count[req.who];
        if (req.op == CMD_ALLOC)
        begin
            if (cnt == 0)
            begin
                // Refill from the newest global batch, else from a fresh slab.
                if (shadow_batch_count > 0)
                begin
                    shadow_batch_count--;
                    g = shadow_batch_count * BATCH;
                    for (int i = 0; i < BATCH; i++)
                        shadow_stack[req.who][i] = shadow_batches[g + i];
                end
                else if (shadow_slabs < NSLABS)
                begin
                    first = shadow_slabs * BATCH;
                    for (int i = 0; i < BATCH; i++)
                        shadow_stack[req.who][i] = IDX_W'(first + i);
                    shadow_slabs++;
                end
                else
                begin
                    res.stat = STATUS_EXHAUSTED;
                    return res;
                end
                cnt = BATCH;
            end
            cnt--;
            res.block = shadow_stack[req.who][cnt];
            shadow_count[req.who] = cnt;
            return res;
        end
        // A free that would spill into a full global store is dropped.
        if (cnt >= 2 * BATCH && shadow_batch_count >= NSLABS)
            return res;
        shadow_stack[req.who][cnt] = req.idx;
        cnt++;
        if (cnt > 2 * BATCH)
        begin
            g = shadow_batch_count * BATCH;
            for (int i = 0; i < BATCH; i++)
            begin
                cnt--;
                shadow_batches[g + i] = shadow_stack[req.who][cnt];
            end
            shadow_batch_count++;
        end
        shadow_count[req.who] = cnt;
        return res;
    endfunction

    // Request driver: holds a transfer until accepted, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        request_t next_req;
        if (!rst_n)
        begin
            start    <= 1'b0;
            gap_left <= 0;
        end
        else if (!start || !busy)
        begin
            if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (gaps_on && $urandom_range(0, 99) < 12)
            begin
                start    <= 1'b0;
                gap_left <= $urandom_range(1, 17) - 1;
            end
            else if (pending_requests.size() != 0)
            begin
                next_req    = pending_requests.pop_front();
                start       <= 1'b1;
                cmd         <= next_req.op;
                requester   <= next_req.who;
                freed_block <= next_req.idx;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor: checks each strobe, then predicts each accepted transfer.
    always @(posedge clk)
    begin : grant_monitor
        grant_t   want;
        request_t got_req;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_grants.size() == 0)
                begin
                    $display("%0t: result with no request waiting: granted_block %0d status %0d",
                             $time, granted_block, status);
                    error_count++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (granted_block !== want.block)
                    begin
                        $display("%0t: granted_block expected %0d actual %0d",
                                 $time, want.block, granted_block);
                        error_count++;
                    end
                    if (status !== want.stat)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.stat, status);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                got_req.op  = cmd;
                got_req.who = requester;
                got_req.idx = freed_block;
                expected_grants.insert(expected_grants.size(), predict_grant(got_req));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_request(logic op, int unsigned who, int unsigned idx);
        request_t req;
        req.op  = op;
        req.who = REQ_W'(who);
        req.idx = IDX_W'(idx);
        pending_requests.insert(pending_requests.size(), req);
    endtask

    // Sender pause: waits until every queued transfer has been answered.
    task automatic wait_quiet();
        @(negedge clk);
        while (pending_requests.size() != 0 || start || expected_grants.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned n_items;
        int unsigned who;
        int unsigned run;
        int unsigned pick;

        for (int r = 0; r < NREQ; r++)
            shadow_count[r] = 0;

        // Hold reset low, then release it.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: slab creation, field extremes, local push and pop.
        queue_request(CMD_ALLOC, 0, 0);
        queue_request(CMD_ALLOC, 0, 1023);
        queue_request(CMD_FREE, 0, 1023);
        queue_request(CMD_ALLOC, 0, 0);
        queue_request(CMD_FREE, 7, 0);
        queue_request(CMD_ALLOC, 7, 1023);
        queue_request(CMD_ALLOC, 7, 0);
        queue_request(CMD_FREE, 3, 10'h2AA);
        queue_request(CMD_FREE, 3, 10'h155);
        queue_request(CMD_ALLOC, 3, 0);
        queue_request(CMD_ALLOC, 3, 0);
        queue_request(CMD_ALLOC, 3, 0);
        queue_request(CMD_FREE, 5, 512);
        queue_request(CMD_FREE, 5, 511);
        queue_request(CMD_ALLOC, 5, 0);
        queue_request(CMD_ALLOC, 6, 0);
        queue_request(CMD_FREE, 6, 1023);
        // Overflow one local stack into a global batch, then refill another
        // stack from that batch and finally from a fresh slab.
        repeat (33)
            queue_request(CMD_FREE, 1, $urandom_range(0, 1023));
        repeat (17)
            queue_request(CMD_ALLOC, 2, 0);
        wait_quiet();

        // Random part: runs of allocates or frees per requester, plus noise.
        gaps_on = 1'b1;
        n_items = 0;
        while (n_items < 380)
        begin
            who  = $urandom_range(0, NREQ - 1);
            pick = $urandom_range(0, 9);
            run  = (pick < 9) ? $urandom_range(1, 40) : 1;
            for (int k = 0; k < run; k++)
            begin
                if (pick == 9)
                    queue_request(1'($urandom_range(0, 1)), $urandom_range(0, NREQ - 1),
                                  $urandom_range(0, 1023));
                else if (pick < 5)
                    queue_request(CMD_ALLOC, who, $urandom_range(0, 1023));
                else
                    queue_request(CMD_FREE, who, $urandom_range(0, 1023));
            end
            n_items += run;
            if (n_items >= 190 && n_items < 190 + run)
                wait_quiet();
        end
        wait_quiet();

        // Last part without idling: back-to-back allocates and frees.
        gaps_on = 1'b0;
        for (int r = 0; r < NREQ; r++)
        begin
            repeat (12)
                queue_request(CMD_ALLOC, r, $urandom_range(0, 1023));
            queue_request(CMD_FREE, r, $urandom_range(0, 1023));
        end
        wait_quiet();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
